@@ hdl/lcdnw_pkg.sv @@
// shared types, constants and step tables for the lcd nibble write sequencer
package lcdnw_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int HOLD_W   = 13;

    // hold times in microseconds
    localparam logic [HOLD_W-1:0] HOLD_ZERO   = 13'd0;
    localparam logic [HOLD_W-1:0] HOLD_SHORT  = 13'd2;
    localparam logic [HOLD_W-1:0] HOLD_CMD    = 13'd50;
    localparam logic [HOLD_W-1:0] HOLD_STROBE = 13'd100;
    localparam logic [HOLD_W-1:0] HOLD_SETTLE = 13'd5000;
    localparam logic [HOLD_W-1:0] HOLD_CMD_SETTLE = 13'd5050;

    // rs levels
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // sequence positions
    localparam int            STEP_W        = 4;
    localparam logic [3:0]    RESET_LAST    = 4'd10;
    localparam logic [3:0]    BYTE_LAST     = 4'd5;
    localparam logic [3:0]    BYTE_HI_LAST  = 4'd2;
    localparam logic [3:0]    BYTE_STROBE_HI = 4'd1;
    localparam logic [3:0]    BYTE_STROBE_LO = 4'd4;
    localparam int            CMD_IDX_W     = 3;
    localparam logic [2:0]    INIT_CMD_LAST = 3'd4;

    // cursor address bases
    localparam logic [BYTE_W-1:0] CURSOR_LINE0 = 8'h80;
    localparam logic [BYTE_W-1:0] CURSOR_LINE1 = 8'hC0;

    // job queue geometry
    localparam int              QDEPTH = 2;
    localparam int              QPTR_W = 1;
    localparam int              QCNT_W = 2;
    localparam logic [QCNT_W-1:0] QCNT_FULL = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CMD    = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_CURSOR = 2'd2,
        ACT_INIT   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_RESET = 2'd1,
        SEQ_BYTE  = 2'd2
    } t_seq_state;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_init;
        logic              rs;
        logic [BYTE_W-1:0] byte_val;
        logic [HOLD_W-1:0] final_hold;
    } t_job;

    // one pin step as seen on the result side
    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_pin_step;

    // queue status between queue and its neighbors
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // power-up reset nibbles, all with rs low and never last
    function automatic t_pin_step reset_step(input logic [STEP_W-1:0] idx);
        t_pin_step s;
        s = '{nibble: 4'h0, reg_select: RS_CMD, enable: 1'b0,
              hold_us: HOLD_ZERO, last: 1'b0};
        case (idx)
            4'd0:  begin s.nibble = 4'h0; s.enable = 1'b0; s.hold_us = HOLD_ZERO;   end
            4'd1:  begin s.nibble = 4'h3; s.enable = 1'b0; s.hold_us = HOLD_ZERO;   end
            4'd2:  begin s.nibble = 4'h3; s.enable = 1'b1; s.hold_us = HOLD_STROBE; end
            4'd3:  begin s.nibble = 4'h3; s.enable = 1'b0; s.hold_us = HOLD_SETTLE; end
            4'd4:  begin s.nibble = 4'h3; s.enable = 1'b1; s.hold_us = HOLD_STROBE; end
            4'd5:  begin s.nibble = 4'h3; s.enable = 1'b0; s.hold_us = HOLD_SETTLE; end
            4'd6:  begin s.nibble = 4'h3; s.enable = 1'b1; s.hold_us = HOLD_STROBE; end
            4'd7:  begin s.nibble = 4'h3; s.enable = 1'b0; s.hold_us = HOLD_SETTLE; end
            4'd8:  begin s.nibble = 4'h2; s.enable = 1'b0; s.hold_us = HOLD_ZERO;   end
            4'd9:  begin s.nibble = 4'h2; s.enable = 1'b1; s.hold_us = HOLD_STROBE; end
            4'd10: begin s.nibble = 4'h2; s.enable = 1'b0; s.hold_us = HOLD_SETTLE; end
            default: begin s.nibble = 4'h0; s.enable = 1'b0; s.hold_us = HOLD_ZERO; end
        endcase
        return s;
    endfunction

    // setup commands sent after the reset nibbles
    function automatic logic [BYTE_W-1:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/char_lcd_nibble_write_sequencer.sv @@
// top level of the 4-bit character lcd write sequencer
//
// Each request becomes the pin steps for a character lcd on a 4-bit bus,
// one step per result beat, each with the microseconds to hold it. Command,
// data and cursor requests produce six steps, init produces 41. The back
// sequencer emits one step per clock while results are popped every cycle;
// the next request is loaded in the same cycle as the last step of the one
// before, so requests follow with no gap. A two-entry job queue and a
// holding register in front let up to three requests wait while the
// sequencer is busy. A push passes the front holding register, the job queue
// and the back job register before its first step is in the result register.
module char_lcd_nibble_write_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [lcdnw_pkg::ACTION_W-1:0] i_action,
    input  logic [lcdnw_pkg::BYTE_W-1:0]   i_value,
    input  logic                           i_line,
    input  logic [lcdnw_pkg::NIB_W-1:0]    i_column,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [lcdnw_pkg::NIB_W-1:0]    o_nibble,
    output logic                           o_reg_select,
    output logic                           o_enable,
    output logic [lcdnw_pkg::HOLD_W-1:0]   o_hold_us,
    output logic                           o_last
);

    logic                 w_front_valid;
    lcdnw_pkg::t_job      w_front_job;
    lcdnw_pkg::t_job      w_q_job;
    lcdnw_pkg::t_q_status w_q_status;
    logic                 w_job_take;
    lcdnw_pkg::t_pin_step w_step;

    // request intake and classification
    lcdnw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_line      (i_line),
        .i_column    (i_column),
        .o_full      (o_full),
        .i_q_full    (w_q_status.full),
        .o_job_valid (w_front_valid),
        .o_job       (w_front_job)
    );

    // job queue
    lcdnw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_front_valid),
        .i_wr_job (w_front_job),
        .i_rd     (w_job_take),
        .o_rd_job (w_q_job),
        .o_status (w_q_status)
    );

    // step sequencer and result register
    lcdnw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_status.empty),
        .i_job       (w_q_job),
        .o_job_take  (w_job_take),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_step      (w_step)
    );

    assign o_nibble     = w_step.nibble;
    assign o_reg_select = w_step.reg_select;
    assign o_enable     = w_step.enable;
    assign o_hold_us    = w_step.hold_us;
    assign o_last       = w_step.last;

    // queue fill count never passes its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= lcdnw_pkg::QCNT_FULL)
        else $error("job queue count out of range");

    // the sequencer only takes a job the queue holds
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_take |-> !w_q_status.empty)
        else $error("job taken from empty queue");

    // a strobe step is always short or a strobe hold
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_enable) |->
        (o_hold_us == lcdnw_pkg::HOLD_SHORT || o_hold_us == lcdnw_pkg::HOLD_STROBE))
        else $error("strobe step with wrong hold");

    // a sequence never ends with enable high
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> !o_enable)
        else $error("last step with enable high");

endmodule

@@ hdl/lcdnw_front.sv @@
// front stage: accepts requests and classifies them into jobs
module lcdnw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [lcdnw_pkg::ACTION_W-1:0] i_action,
    input  logic [lcdnw_pkg::BYTE_W-1:0]   i_value,
    input  logic                          i_line,
    input  logic [lcdnw_pkg::NIB_W-1:0]    i_column,
    output logic                          o_full,
    input  logic                          i_q_full,
    output logic                          o_job_valid,
    output lcdnw_pkg::t_job               o_job
);

    logic             r_valid;
    logic             n_valid;
    lcdnw_pkg::t_job  r_job;
    lcdnw_pkg::t_job  w_job;
    logic             w_accept;
    lcdnw_pkg::t_action w_action;

    // holding register stays full only while the queue refuses it
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign n_valid  = w_accept || (r_valid && i_q_full);

    // classify the request
    always_comb begin
        w_action         = lcdnw_pkg::t_action'(i_action);
        w_job.is_init    = 1'b0;
        w_job.rs         = lcdnw_pkg::RS_CMD;
        w_job.byte_val   = i_value;
        w_job.final_hold = lcdnw_pkg::HOLD_CMD;
        case (w_action)
            lcdnw_pkg::ACT_CMD: begin
                w_job.rs = lcdnw_pkg::RS_CMD;
            end
            lcdnw_pkg::ACT_DATA: begin
                w_job.rs = lcdnw_pkg::RS_DATA;
            end
            lcdnw_pkg::ACT_CURSOR: begin
                w_job.byte_val   = (i_line ? lcdnw_pkg::CURSOR_LINE1 : lcdnw_pkg::CURSOR_LINE0)
                                   | {4'h0, i_column};
                w_job.final_hold = lcdnw_pkg::HOLD_CMD_SETTLE;
            end
            lcdnw_pkg::ACT_INIT: begin
                w_job.is_init    = 1'b1;
                w_job.final_hold = lcdnw_pkg::HOLD_CMD_SETTLE;
            end
            default: begin
                w_job.is_init = 1'b0;
            end
        endcase
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= w_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

@@ hdl/lcdnw_queue.sv @@
// short job queue between the front and the back
module lcdnw_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  lcdnw_pkg::t_job      i_wr_job,
    input  logic                 i_rd,
    output lcdnw_pkg::t_job      o_rd_job,
    output lcdnw_pkg::t_q_status o_status
);

    lcdnw_pkg::t_job                 r_mem [lcdnw_pkg::QDEPTH];
    logic [lcdnw_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [lcdnw_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [lcdnw_pkg::QCNT_W-1:0]    r_count;
    logic                            w_wr;
    logic                            w_rd;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == lcdnw_pkg::QCNT_FULL);
    assign o_status.empty = (r_count == '0);

    assign w_wr = i_wr && !o_status.full;
    assign w_rd = i_rd && !o_status.empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    assign o_rd_job = r_mem[r_rd_ptr];

endmodule

@@ hdl/lcdnw_back.sv @@
// back stage: expands each job into pin steps, one step per cycle while the result slot is free or popped
module lcdnw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  lcdnw_pkg::t_job      i_job,
    output logic                 o_job_take,
    input  logic                 i_pop,
    output logic                 o_empty,
    output lcdnw_pkg::t_pin_step o_step
);

    lcdnw_pkg::t_seq_state                r_state;
    lcdnw_pkg::t_seq_state                n_state;
    lcdnw_pkg::t_job                      r_job;
    logic [lcdnw_pkg::STEP_W-1:0]         r_step;
    logic [lcdnw_pkg::CMD_IDX_W-1:0]      r_cmd_idx;
    logic                                 r_out_valid;
    lcdnw_pkg::t_pin_step                 r_out;
    lcdnw_pkg::t_pin_step                 w_step;
    logic [lcdnw_pkg::BYTE_W-1:0]         w_byte;
    logic                                 w_adv;
    logic                                 w_take;

    // a step goes out whenever there is work and the output slot frees up
    assign w_adv  = (r_state != lcdnw_pkg::SEQ_IDLE) && (!r_out_valid || i_pop);
    assign w_take = i_job_valid && ((r_state == lcdnw_pkg::SEQ_IDLE) || (w_adv && w_step.last));
    assign o_job_take = w_take;

    // next state
    always_comb begin
        n_state = r_state;
        if (w_take) begin
            n_state = i_job.is_init ? lcdnw_pkg::SEQ_RESET : lcdnw_pkg::SEQ_BYTE;
        end else if (w_adv) begin
            case (r_state)
                lcdnw_pkg::SEQ_RESET: begin
                    if (r_step == lcdnw_pkg::RESET_LAST) begin
                        n_state = lcdnw_pkg::SEQ_BYTE;
                    end
                end
                lcdnw_pkg::SEQ_BYTE: begin
                    if (w_step.last) begin
                        n_state = lcdnw_pkg::SEQ_IDLE;
                    end
                end
                default: n_state = r_state;
            endcase
        end
    end

    // pin levels of the current step
    always_comb begin
        w_byte = r_job.is_init ? lcdnw_pkg::init_cmd(r_cmd_idx) : r_job.byte_val;
        w_step = '{nibble: 4'h0, reg_select: lcdnw_pkg::RS_CMD, enable: 1'b0,
                   hold_us: lcdnw_pkg::HOLD_ZERO, last: 1'b0};
        case (r_state)
            lcdnw_pkg::SEQ_RESET: begin
                w_step = lcdnw_pkg::reset_step(r_step);
            end
            lcdnw_pkg::SEQ_BYTE: begin
                w_step.nibble     = (r_step <= lcdnw_pkg::BYTE_HI_LAST) ?
                                    w_byte[7:4] : w_byte[3:0];
                w_step.reg_select = r_job.rs;
                w_step.enable     = (r_step == lcdnw_pkg::BYTE_STROBE_HI) ||
                                    (r_step == lcdnw_pkg::BYTE_STROBE_LO);
                w_step.hold_us    = (r_step == lcdnw_pkg::BYTE_LAST) ?
                                    r_job.final_hold : lcdnw_pkg::HOLD_SHORT;
                w_step.last       = (r_step == lcdnw_pkg::BYTE_LAST) &&
                                    (!r_job.is_init ||
                                     (r_cmd_idx == lcdnw_pkg::INIT_CMD_LAST));
            end
            default: begin
                w_step.last = 1'b0;
            end
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcdnw_pkg::SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job, counters and output payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job     <= i_job;
            r_step    <= '0;
            r_cmd_idx <= '0;
        end else if (w_adv) begin
            case (r_state)
                lcdnw_pkg::SEQ_RESET: begin
                    r_step <= (r_step == lcdnw_pkg::RESET_LAST) ? '0 : r_step + 1'b1;
                end
                lcdnw_pkg::SEQ_BYTE: begin
                    if (r_step == lcdnw_pkg::BYTE_LAST) begin
                        r_step    <= '0;
                        r_cmd_idx <= r_cmd_idx + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_step <= r_step;
            endcase
        end
        if (w_adv) begin
            r_out <= w_step;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_step  = r_out;

endmodule
